// ===== rtl/jbvm_pkg.sv =====
// Shared constants, codes and helpers for the jitter-buffered voice mixer.
// Depends on nothing; imported by jitter_buffered_voice_mixer_unit.
package jbvm_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int FIFO_DEPTH  = 4096;
   localparam int MAX_REQUEST = 64;

   localparam int SAMPLE_W  = 16;
   localparam int ACTION_W  = 2;
   localparam int SLOT_FW   = 3;
   localparam int REQ_W     = 7;
   localparam int TARGET_W  = 13;
   localparam int UNDERRUN_W = 32;

   localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   localparam int FILL_W   = PTR_W + 1;
   localparam int ACC_W    = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
   localparam int CNT_W    = $clog2(MAX_REQUEST + 1);
   localparam int STORE_AW = SLOT_W + PTR_W;
   localparam int STORE_DEPTH = NUM_SLOTS * FIFO_DEPTH;

   localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(960);

   localparam logic [ACTION_W-1:0] ACT_PUSH    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_MIX     = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_SLOT_CHECK = 8'b0000_0010,
      ST_MIX_RD     = 8'b0000_0100,
      ST_MIX_ACC    = 8'b0000_1000,
      ST_SCAN_DONE  = 8'b0001_0000,
      ST_OUT_READ   = 8'b0010_0000,
      ST_OUT_LOAD   = 8'b0100_0000,
      ST_OUT_EMPTY  = 8'b1000_0000
   } state_type;

   // Add two samples and clamp to the 16-bit range.
   function automatic logic signed [SAMPLE_W-1:0] sat_add(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b
   );
      logic signed [SAMPLE_W:0] sum;
      sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
         sat_add = sum[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                 : {1'b0, {(SAMPLE_W-1){1'b1}}};
      end else begin
         sat_add = sum[SAMPLE_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/jitter_buffered_voice_mixer_unit.sv =====
// Jitter-buffered voice mixer: per-slot sample FIFOs in one shared store,
// a mix sequencer with one saturating adder, and a registered result beat.
// Depends on jbvm_pkg.
//
// Usage:
//   req channel (valid/ready) carries push, release and mix request beats.
//   Push and release are handled in the idle state; req_ready stays high for them.
//   A mix request walks the eight slots one after another: a check state
//   decides per slot, then each popped sample passes ST_MIX_RD and ST_MIX_ACC
//   through the single adder (one store read port, one accumulator port).
//   Each result beat is read in ST_OUT_READ and loaded in ST_OUT_LOAD.
//   rsp channel (valid/ready) returns one beat per mixed position, the
//   last one flagged; an empty mix returns a single empty beat.
//   The result register holds a beat while rsp_ready is low; the sequencer
//   waits before loading the next one, and pushes are still taken while
//   the final beat of a request waits.
//   csr_wr_en writes the prime target (reset 960).
//   Reset clears slot flags, pointers, fill counts and the underrun count;
//   the sample store is not cleared and needs no sweep.
module jitter_buffered_voice_mixer_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [jbvm_pkg::ACTION_W-1:0]          req_action,
   input  logic [jbvm_pkg::SLOT_FW-1:0]           req_slot,
   input  logic signed [jbvm_pkg::SAMPLE_W-1:0]   req_sample_in,
   input  logic [jbvm_pkg::REQ_W-1:0]             req_request_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [jbvm_pkg::SAMPLE_W-1:0]   rsp_mixed_sample,
   output logic                                   rsp_is_last,
   output logic                                   rsp_is_empty,
   output logic [jbvm_pkg::UNDERRUN_W-1:0]        rsp_underrun_total,
   input  logic                                   csr_wr_en,
   input  logic [jbvm_pkg::TARGET_W-1:0]          csr_wr_data
);
   import jbvm_pkg::*;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
   localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_REQUEST);

   // control state
   state_type              state_ff, state_in;
   logic [PTR_W-1:0]       rp_ff [NUM_SLOTS];
   logic [PTR_W-1:0]       rp_in [NUM_SLOTS];
   logic [FILL_W-1:0]      fill_ff [NUM_SLOTS];
   logic [FILL_W-1:0]      fill_in [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]   active_ff, active_in;
   logic [NUM_SLOTS-1:0]   primed_ff, primed_in;
   logic [UNDERRUN_W-1:0]  underrun_ff, underrun_in;
   logic [TARGET_W-1:0]    target_ff, target_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // sequencer working registers
   logic [CNT_W-1:0]       n_ff, n_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [CNT_W-1:0]       i_ff, i_in;
   logic [CNT_W-1:0]       mixed_ff, mixed_in;
   logic [CNT_W-1:0]       o_ff, o_in;
   logic [SLOT_W-1:0]      s_ff, s_in;

   // result beat
   logic signed [SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_empty_ff, rsp_empty_in;
   logic [UNDERRUN_W-1:0]  rsp_under_ff, rsp_under_in;

   // memories
   logic [SAMPLE_W-1:0]    store_mem [STORE_DEPTH];
   logic [SAMPLE_W-1:0]    acc_mem [MAX_REQUEST];
   logic signed [SAMPLE_W-1:0] store_rd_ff;
   logic signed [SAMPLE_W-1:0] acc_rd_ff;
   logic                   store_we, store_re, acc_we, acc_re;
   logic [STORE_AW-1:0]    store_waddr, store_raddr;
   logic [SAMPLE_W-1:0]    store_wdata;
   logic [ACC_W-1:0]       acc_waddr, acc_raddr;
   logic [SAMPLE_W-1:0]    acc_wdata;

   // helpers
   logic [SLOT_W-1:0]      ps;
   logic                   slot_ok;
   logic [FILL_W-1:0]      push_fill;
   logic [PTR_W-1:0]       push_rp;
   logic [CNT_W-1:0]       req_n;
   logic [CNT_W-1:0]       scan_k;
   logic                   out_free;
   logic [CNT_W-1:0]       i_inc;
   logic [CNT_W-1:0]       o_inc;
   state_type              adv_state;
   logic [SLOT_W-1:0]      adv_s;

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_mixed_sample   = rsp_sample_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_is_empty       = rsp_empty_ff;
   assign rsp_underrun_total = rsp_under_ff;

   assign ps        = req_slot[SLOT_W-1:0];
   assign slot_ok   = (32'(req_slot) < NUM_SLOTS);
   assign push_fill = active_ff[ps] ? fill_ff[ps] : '0;
   assign push_rp   = active_ff[ps] ? rp_ff[ps] : '0;
   assign req_n     = (CNT_W'(req_request_count) > MAX_N) ? MAX_N
                                                          : CNT_W'(req_request_count);
   assign scan_k    = (fill_ff[s_ff] < FILL_W'(n_ff)) ? CNT_W'(fill_ff[s_ff]) : n_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign i_inc     = i_ff + CNT_W'(1);
   assign o_inc     = o_ff + CNT_W'(1);
   assign adv_state = (s_ff == LAST_SLOT) ? ST_SCAN_DONE : ST_SLOT_CHECK;
   assign adv_s     = s_ff + SLOT_W'(1);

   always_comb begin
      state_in      = state_ff;
      rp_in         = rp_ff;
      fill_in       = fill_ff;
      active_in     = active_ff;
      primed_in     = primed_ff;
      underrun_in   = underrun_ff;
      target_in     = target_ff;
      rsp_valid_in  = rsp_valid_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      mixed_in      = mixed_ff;
      o_in          = o_ff;
      s_in          = s_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_under_in  = rsp_under_ff;
      store_we      = 1'b0;
      store_waddr   = {ps, push_rp + push_fill[PTR_W-1:0]};
      store_wdata   = req_sample_in;
      store_re      = 1'b0;
      store_raddr   = {s_ff, rp_ff[s_ff] + PTR_W'(i_ff)};
      acc_we        = 1'b0;
      acc_waddr     = i_ff[ACC_W-1:0];
      acc_wdata     = store_rd_ff;
      acc_re        = 1'b0;
      acc_raddr     = i_ff[ACC_W-1:0];

      if (csr_wr_en) begin
         target_in = csr_wr_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_action)
                  ACT_PUSH: begin
                     if (slot_ok) begin
                        // claim an inactive slot: empty FIFO, unprimed
                        active_in[ps] = 1'b1;
                        if (!active_ff[ps]) begin
                           primed_in[ps] = 1'b0;
                           rp_in[ps]     = '0;
                           fill_in[ps]   = '0;
                        end
                        if (push_fill < FILL_W'(FIFO_DEPTH)) begin
                           store_we    = 1'b1;
                           fill_in[ps] = push_fill + FILL_W'(1);
                        end
                     end
                  end
                  ACT_RELEASE: begin
                     if (slot_ok) begin
                        active_in[ps] = 1'b0;
                     end
                  end
                  ACT_MIX: begin
                     n_in     = req_n;
                     mixed_in = '0;
                     s_in     = '0;
                     state_in = (req_n == '0) ? ST_SCAN_DONE : ST_SLOT_CHECK;
                  end
                  default: ;
               endcase
            end
         end
         ST_SLOT_CHECK: begin
            if (active_ff[s_ff] &&
                (primed_ff[s_ff] || (fill_ff[s_ff] >= FILL_W'(target_ff)))) begin
               k_in = scan_k;
               i_in = '0;
               // a short pop unprimes the slot and counts an underrun
               primed_in[s_ff] = (scan_k == n_ff);
               if (scan_k != n_ff) begin
                  underrun_in = underrun_ff + UNDERRUN_W'(1);
               end
               if (scan_k == '0) begin
                  state_in = adv_state;
                  s_in     = adv_s;
               end else begin
                  state_in = ST_MIX_RD;
               end
            end else begin
               state_in = adv_state;
               s_in     = adv_s;
            end
         end
         ST_MIX_RD: begin
            store_re = 1'b1;
            acc_re   = 1'b1;
            state_in = ST_MIX_ACC;
         end
         ST_MIX_ACC: begin
            acc_we = 1'b1;
            if (i_ff < mixed_ff) begin
               acc_wdata = sat_add(acc_rd_ff, store_rd_ff);
            end
            i_in = i_inc;
            if (i_inc == k_ff) begin
               rp_in[s_ff]   = rp_ff[s_ff] + PTR_W'(k_ff);
               fill_in[s_ff] = fill_ff[s_ff] - FILL_W'(k_ff);
               if (k_ff > mixed_ff) begin
                  mixed_in = k_ff;
               end
               state_in = adv_state;
               s_in     = adv_s;
            end else begin
               state_in = ST_MIX_RD;
            end
         end
         ST_SCAN_DONE: begin
            o_in     = '0;
            state_in = (mixed_ff == '0) ? ST_OUT_EMPTY : ST_OUT_READ;
         end
         ST_OUT_READ: begin
            acc_re    = 1'b1;
            acc_raddr = o_ff[ACC_W-1:0];
            state_in  = ST_OUT_LOAD;
         end
         ST_OUT_LOAD: begin
            // hold until the result register is free
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = acc_rd_ff;
               rsp_last_in   = (o_inc == mixed_ff);
               rsp_empty_in  = 1'b0;
               rsp_under_in  = underrun_ff;
               o_in          = o_inc;
               state_in      = (o_inc == mixed_ff) ? ST_IDLE : ST_OUT_READ;
            end
         end
         ST_OUT_EMPTY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = '0;
               rsp_last_in   = 1'b1;
               rsp_empty_in  = 1'b1;
               rsp_under_in  = underrun_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         primed_ff    <= '0;
         underrun_ff  <= '0;
         target_ff    <= TARGET_RESET;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < NUM_SLOTS; j++) begin
            rp_ff[j]   <= '0;
            fill_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         primed_ff    <= primed_in;
         underrun_ff  <= underrun_in;
         target_ff    <= target_in;
         rsp_valid_ff <= rsp_valid_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      k_ff          <= k_in;
      i_ff          <= i_in;
      mixed_ff      <= mixed_in;
      o_ff          <= o_in;
      s_ff          <= s_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_under_ff  <= rsp_under_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (store_re) begin
         store_rd_ff <= store_mem[store_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[acc_waddr] <= acc_wdata;
      end
      if (acc_re) begin
         acc_rd_ff <= acc_mem[acc_raddr];
      end
   end

`ifndef SYNTHESIS
   a_empty_beat_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_empty_ff |-> rsp_last_ff && (rsp_sample_ff == '0))
      else $error("empty beat not flagged last or not zero");

   a_underrun_step: assert property (@(posedge clock) disable iff (reset)
      (underrun_in != underrun_ff) |-> (underrun_in == underrun_ff + UNDERRUN_W'(1)))
      else $error("underrun count moved by more than one");

   a_pop_within_k: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX_ACC) |-> (i_ff < k_ff) && (k_ff <= n_ff))
      else $error("pop index beyond pop length");

   a_scan_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SLOT_CHECK) |-> (n_ff != '0) && (n_ff <= MAX_N))
      else $error("slot scan with empty request");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT_LOAD) && rsp_valid_ff && !rsp_ready |=> $stable(rsp_sample_ff))
      else $error("pending result overwritten");
`endif

endmodule
